/* src/pec_pkg.sv */
// shared types, constants and character helpers for the percent-escape codec
package pec_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        MODE_FORM_ENC = 2'd0,
        MODE_URL_ENC  = 2'd1,
        MODE_DECODE   = 2'd2,
        MODE_PASS     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    typedef enum logic [1:0] {
        BEAT_PCT = 2'd0,
        BEAT_HI  = 2'd1,
        BEAT_LO  = 2'd2
    } beat_t;

    // one queued job: a plain result byte or a byte to be escaped as three
    typedef struct packed {
        logic       esc;
        logic [7:0] data;
        logic       bad;
        logic       last;
    } job_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic form_plain(input logic [7:0] c);
        return is_alnum(c) || c == 8'h2D || c == 8'h5F || c == 8'h2E || c == 8'h2A;
    endfunction

    function automatic logic url_plain(input logic [7:0] c);
        return form_plain(c) || c == 8'h7C || c == 8'h7E || c == 8'h27 || c == 8'h28
            || c == 8'h29 || c == 8'h3B || c == 8'h2F || c == 8'h3F || c == 8'h3A
            || c == 8'h40 || c == 8'h26 || c == 8'h3D || c == 8'h2B || c == 8'h24
            || c == 8'h2C;
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h37;
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
    endfunction

endpackage

/* src/pec_front.sv */
// front end: takes input items, holds mode and escape state, builds jobs
module pec_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output pec_pkg::job_t     q_job
);
    import pec_pkg::*;

    mode_t      mode_reg, mode_next;
    esc_phase_t phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;
    logic       fbad_reg, fbad_next;
    logic       take;
    logic       emit;
    job_t       job;

    // a mode write holds off the input for that cycle
    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full && !cfg_valid;
    assign take      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FORM_ENC;
            phase_reg <= ESC_IDLE;
            nib_reg   <= 4'h0;
            fbad_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            fbad_reg  <= fbad_next;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        nib_next   = nib_reg;
        fbad_next  = fbad_reg;
        emit       = 1'b0;
        job        = '{esc: 1'b0, data: s_tdata, bad: 1'b0, last: s_tlast};

        if (cfg_valid)
        begin
            mode_next  = mode_t'(cfg_data);
            phase_next = ESC_IDLE;
            nib_next   = 4'h0;
            fbad_next  = 1'b0;
        end
        else if (take)
        begin
            case (mode_reg)
                MODE_FORM_ENC, MODE_URL_ENC:
                begin
                    emit = 1'b1;
                    if ((mode_reg == MODE_FORM_ENC) ? form_plain(s_tdata)
                                                    : url_plain(s_tdata))
                        job.data = s_tdata;
                    else if (mode_reg == MODE_FORM_ENC && s_tdata == CH_SPACE)
                        job.data = CH_PLUS;
                    else
                        job.esc = 1'b1;
                end
                MODE_DECODE:
                begin
                    case (phase_reg)
                        ESC_HIGH:
                        begin
                            // first digit; a cut-off escape reports it at once
                            if (s_tlast)
                            begin
                                emit       = 1'b1;
                                job.bad    = 1'b1;
                                job.data   = hex_ok(s_tdata) ? {4'h0, hex_val(s_tdata)}
                                                             : 8'h00;
                                phase_next = ESC_IDLE;
                                nib_next   = 4'h0;
                                fbad_next  = 1'b0;
                            end
                            else
                            begin
                                phase_next = ESC_LOW;
                                fbad_next  = !hex_ok(s_tdata);
                                nib_next   = hex_ok(s_tdata) ? hex_val(s_tdata) : 4'h0;
                            end
                        end
                        ESC_LOW:
                        begin
                            emit = 1'b1;
                            if (fbad_reg)
                            begin
                                job.data = 8'h00;
                                job.bad  = 1'b1;
                            end
                            else if (!hex_ok(s_tdata))
                            begin
                                job.data = {4'h0, nib_reg};
                                job.bad  = 1'b1;
                            end
                            else
                                job.data = {nib_reg, hex_val(s_tdata)};
                            phase_next = ESC_IDLE;
                            nib_next   = 4'h0;
                            fbad_next  = 1'b0;
                        end
                        default:
                        begin
                            if (s_tdata == CH_PERCENT)
                            begin
                                if (s_tlast)
                                begin
                                    emit     = 1'b1;
                                    job.data = 8'h00;
                                    job.bad  = 1'b1;
                                end
                                else
                                    phase_next = ESC_HIGH;
                                nib_next  = 4'h0;
                                fbad_next = 1'b0;
                            end
                            else
                            begin
                                emit     = 1'b1;
                                job.data = (s_tdata == CH_PLUS) ? CH_SPACE : s_tdata;
                            end
                        end
                    endcase
                end
                default:
                begin
                    emit = 1'b1;
                end
            endcase
        end
    end

    assign q_push = emit;
    assign q_job  = job;

endmodule

/* src/pec_queue.sv */
// short job queue between front and back
module pec_queue #(
    parameter int DEPTH = pec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pec_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output pec_pkg::job_t head_job
);
    import pec_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign nonempty = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head_job = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

/* src/pec_back.sv */
// back end: plays each job out as one or three result items
module pec_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_nonempty,
    input  pec_pkg::job_t q_head,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [1:0]    m_tuser
);
    import pec_pkg::*;

    logic  busy_reg, busy_next;
    job_t  job_reg, job_next;
    beat_t beat_reg, beat_next;
    logic  fire, final_beat;

    assign fire       = busy_reg && m_tready;
    assign final_beat = !job_reg.esc || beat_reg == BEAT_LO;
    assign q_pop      = q_nonempty && (!busy_reg || (fire && final_beat));

    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        beat_next = beat_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            job_next  = q_head;
            beat_next = BEAT_PCT;
        end
        else if (fire && final_beat)
            busy_next = 1'b0;
        else if (fire)
            beat_next = (beat_reg == BEAT_PCT) ? BEAT_HI : BEAT_LO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_PCT;
        end
        else
        begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_comb
    begin
        m_tdata = job_reg.data;
        if (job_reg.esc)
        begin
            case (beat_reg)
                BEAT_PCT: m_tdata = CH_PERCENT;
                BEAT_HI:  m_tdata = hex_char(job_reg.data[7:4]);
                default:  m_tdata = hex_char(job_reg.data[3:0]);
            endcase
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = final_beat && job_reg.last;
    assign m_tuser  = {job_reg.bad, final_beat};

endmodule

/* src/percent_escape_codec_top.sv */
// top level of the percent-escape codec: front end, job queue, back end
// path: an accepted input item is written into the job queue and then loaded into
//   the back end's job register, from which its result is offered
// throughput: one item per cycle for a byte that gives one result, while m_tready
//   holds high and no mode write comes; an escaped byte gives three result items
// reset: async active low; mode returns to form encode, escape state and queue empty
module percent_escape_codec_top #(
    parameter int QUEUE_DEPTH = pec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // mode register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,     // mode
    // input items
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // in_byte
    input  logic       s_tlast,      // stream_last
    // result items
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // out_byte
    output logic       m_tlast,      // stream_end
    output logic [1:0] m_tuser       // [0] run_last, [1] bad_escape
);
    import pec_pkg::*;

    // jobs flowing from front to back
    logic q_push, q_full, q_pop, q_nonempty;
    job_t q_in_job, q_head_job;

    // front classifies each byte and keeps the decode escape state
    pec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_in_job)
    );

    // short queue decouples input stalls from output stalls
    pec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head_job (q_head_job)
    );

    // back expands escaped bytes into percent and two hex digits
    pec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head_job),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
